>>> src/sitd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sitd_pkg
// Shared widths, character codes and types for the signed integer to
// decimal text converter.
// ----------------------------------------------------------------------------
package sitd_pkg;

  // Field widths
  localparam int unsigned ValueW = 64;
  localparam int unsigned CharW  = 8;

  // Decimal digits of the largest magnitude (2^63 has 19 digits)
  localparam int unsigned NumDigits = 19;
  localparam int unsigned BcdW      = 4 * NumDigits;

  // Bit step counter holds 0..ValueW
  localparam int unsigned CntW = $clog2(ValueW + 1);
  // Remaining digit counter holds 0..NumDigits
  localparam int unsigned RemW = $clog2(NumDigits + 1);

  // Character codes
  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharMinus = 8'h2D;
  localparam logic [CharW-1:0] CharNine  = 8'h39;

  // Top level sequencing
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_e;

  // Conversion result handed from the converter to the emitter
  typedef struct packed {
    logic            done;
    logic            negative;
    logic [BcdW-1:0] bcd;
  } dab_res_t;

endpackage : sitd_pkg
`default_nettype wire

>>> src/sitd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sitd_if
// Valid/ready stream channels: the integer input and the character output.
// ----------------------------------------------------------------------------
interface sitd_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [sitd_pkg::ValueW-1:0]   value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface : sitd_in_if

interface sitd_out_if;
  logic                         valid;
  logic                         ready;
  logic [sitd_pkg::CharW-1:0]   character;
  logic                         last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface : sitd_out_if
`default_nettype wire

>>> src/sitd_dabble.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sitd_dabble
// Bit-serial binary to BCD converter: shifts the magnitude in one bit per
// cycle, adding three to every digit of five or more before each shift.
// ----------------------------------------------------------------------------
module sitd_dabble (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic signed [sitd_pkg::ValueW-1:0]  value_i,
  output      sitd_pkg::dab_res_t                  res_o
);

  logic [sitd_pkg::ValueW-1:0] mag_q, mag_d;
  logic [sitd_pkg::BcdW-1:0]   bcd_q, bcd_d;
  logic [sitd_pkg::BcdW-1:0]   bcd_adj;
  logic [sitd_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic                        neg_q, neg_d;
  logic                        done_q, done_d;
  logic                        busy;

  assign busy = (cnt_q != '0);

  // Correct each digit ahead of the shift
  always_comb begin
    for (int i = 0; i < int'(sitd_pkg::NumDigits); i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  // Load the magnitude, then shift one bit per cycle
  always_comb begin
    mag_d  = mag_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    if (start_i) begin
      neg_d = value_i[sitd_pkg::ValueW-1];
      mag_d = value_i[sitd_pkg::ValueW-1] ? (~value_i + 1'b1) : value_i;
      bcd_d = '0;
      cnt_d = sitd_pkg::CntW'(sitd_pkg::ValueW);
    end else if (busy) begin
      bcd_d  = {bcd_adj[sitd_pkg::BcdW-2:0], mag_q[sitd_pkg::ValueW-1]};
      mag_d  = {mag_q[sitd_pkg::ValueW-2:0], 1'b0};
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == sitd_pkg::CntW'(1));
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    bcd_q <= bcd_d;
    neg_q <= neg_d;
  end

  assign res_o.done     = done_q;
  assign res_o.negative = neg_q;
  assign res_o.bcd      = bcd_q;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy)
    else $error("converter started while busy");

  a_done_after_last_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(cnt_q) == sitd_pkg::CntW'(1)) && !busy)
    else $error("done without a final shift step");
`endif

endmodule : sitd_dabble
`default_nettype wire

>>> src/sitd_emit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sitd_emit
// Digit emitter: sends the sign, then shifts the BCD word out one digit per
// cycle while the output beat is free, dropping leading zeros, into a registered output beat.
// ----------------------------------------------------------------------------
module sitd_emit (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire sitd_pkg::dab_res_t res_i,
  output      logic           busy_o,
  sitd_out_if.source          out_o
);

  localparam int unsigned TopLsb = sitd_pkg::BcdW - 4;

  logic [sitd_pkg::BcdW-1:0]  dig_q, dig_d;
  logic [sitd_pkg::RemW-1:0]  rem_q, rem_d;
  logic                       busy_q, busy_d;
  logic                       sign_q, sign_d;
  logic                       lead_q, lead_d;
  logic                       ovalid_q, ovalid_d;
  logic [sitd_pkg::CharW-1:0] ochar_q, ochar_d;
  logic                       olast_q, olast_d;
  logic                       can_load;
  logic [3:0]                 top_dig;
  logic                       skip;

  assign can_load = !ovalid_q || out_o.ready;
  assign top_dig  = dig_q[TopLsb +: 4];
  assign skip     = lead_q && (top_dig == 4'd0) && (rem_q != sitd_pkg::RemW'(1));

  // Step through sign and digits while the output beat is free
  always_comb begin
    dig_d    = dig_q;
    rem_d    = rem_q;
    busy_d   = busy_q;
    sign_d   = sign_q;
    lead_d   = lead_q;
    ovalid_d = ovalid_q && !out_o.ready;
    ochar_d  = ochar_q;
    olast_d  = olast_q;
    if (res_i.done) begin
      busy_d = 1'b1;
      sign_d = res_i.negative;
      dig_d  = res_i.bcd;
      rem_d  = sitd_pkg::RemW'(sitd_pkg::NumDigits);
      lead_d = 1'b1;
    end else if (busy_q && can_load) begin
      if (sign_q) begin
        sign_d   = 1'b0;
        ovalid_d = 1'b1;
        ochar_d  = sitd_pkg::CharMinus;
        olast_d  = 1'b0;
      end else begin
        dig_d = {dig_q[TopLsb-1:0], 4'd0};
        rem_d = rem_q - 1'b1;
        if (rem_q == sitd_pkg::RemW'(1)) begin
          busy_d = 1'b0;
        end
        if (!skip) begin
          lead_d   = 1'b0;
          ovalid_d = 1'b1;
          ochar_d  = sitd_pkg::CharZero + {4'd0, top_dig};
          olast_d  = (rem_q == sitd_pkg::RemW'(1));
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    dig_q   <= dig_d;
    rem_q   <= rem_d;
    sign_q  <= sign_d;
    lead_q  <= lead_d;
    ochar_q <= ochar_d;
    olast_q <= olast_d;
  end

  assign busy_o          = busy_q;
  assign out_o.valid     = ovalid_q;
  assign out_o.character = ochar_q;
  assign out_o.last      = olast_q;

`ifndef SYNTHESIS
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_i.done |-> !busy_q)
    else $error("emitter loaded while busy");

  a_char_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> (ochar_q == sitd_pkg::CharMinus) ||
                 ((ochar_q >= sitd_pkg::CharZero) && (ochar_q <= sitd_pkg::CharNine)))
    else $error("character outside sign and digit codes");

  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && (ochar_q == sitd_pkg::CharMinus)) |-> !olast_q)
    else $error("minus flagged as last character");
`endif

endmodule : sitd_emit
`default_nettype wire

>>> src/signed_integer_to_decimal_text_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence: the bit-serial BCD shift loop runs over all 64 magnitude bits, the
//   result is handed to the emitter, and the emitter sends the sign, then scans
//   the 19 digit positions, one per cycle while the output beat is free.
// Input: a new integer is taken only when idle, once the last digit is loaded out.
// Reset: asynchronous, active low; returns to idle with the output empty.
// ----------------------------------------------------------------------------
// signed_integer_to_decimal_text_top
// Formats a signed 64-bit integer as decimal ASCII, one character per beat,
// most significant first, with the final character flagged.
// ----------------------------------------------------------------------------
module signed_integer_to_decimal_text_top (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  sitd_in_if.sink     in_i,
  sitd_out_if.source  out_o
);

  sitd_pkg::state_e   state_q, state_d;
  sitd_pkg::dab_res_t dab_res;
  logic               emit_busy;
  logic               accept;

  assign accept = in_i.valid && in_i.ready;

  // Binary to BCD conversion
  sitd_dabble u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .value_i (in_i.value),
    .res_o   (dab_res)
  );

  // Character emission
  sitd_emit u_emit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .res_i  (dab_res),
    .busy_o (emit_busy),
    .out_o  (out_o)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sitd_pkg::ST_IDLE: begin
        if (accept) state_d = sitd_pkg::ST_CONV;
      end
      sitd_pkg::ST_CONV: begin
        if (dab_res.done) state_d = sitd_pkg::ST_EMIT;
      end
      sitd_pkg::ST_EMIT: begin
        if (!emit_busy) state_d = sitd_pkg::ST_IDLE;
      end
      default: state_d = sitd_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_i.ready = (state_q == sitd_pkg::ST_IDLE);
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sitd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule : signed_integer_to_decimal_text_top
`default_nettype wire
